### design/meac_pkg.sv
// package for median_ema_alert_conditioner
// shared types, constants and the controller/datapath command struct
package meac_pkg;

    localparam int WINDOW_DEF   = 5;
    localparam int DEBOUNCE_DEF = 3;

    localparam logic [1:0] LVL_NORMAL = 2'd0;
    localparam logic [1:0] LVL_WARN   = 2'd1;
    localparam logic [1:0] LVL_ALERT  = 2'd2;

    localparam logic [1:0] MODE_FULL   = 2'd0;
    localparam logic [1:0] MODE_MEDIAN = 2'd1;
    localparam logic [1:0] MODE_EMA    = 2'd2;
    localparam logic [1:0] MODE_BYPASS = 2'd3;

    localparam logic [2:0] REG_MODE        = 3'd0;
    localparam logic [2:0] REG_ALPHA       = 3'd1;
    localparam logic [2:0] REG_TEMP_WARN   = 3'd2;
    localparam logic [2:0] REG_TEMP_ALARM  = 3'd3;
    localparam logic [2:0] REG_TEMP_BAND   = 3'd4;
    localparam logic [2:0] REG_LIGHT_WARN  = 3'd5;
    localparam logic [2:0] REG_LIGHT_ALARM = 3'd6;
    localparam logic [2:0] REG_LIGHT_BAND  = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT,
        ST_EMA,
        ST_CLASS,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic sort_step;
        logic ema;
        logic classify;
    } t_cmd;

    typedef struct packed {
        logic use_median;
        logic sort_done;
    } t_status;

endpackage

### design/meac_datapath.sv
// datapath: saturation, median windows, ema, classifiers and debounce
// depends on meac_pkg
module meac_datapath #(
    parameter int WINDOW   = meac_pkg::WINDOW_DEF,
    parameter int DEBOUNCE = meac_pkg::DEBOUNCE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  meac_pkg::t_cmd    i_cmd,
    output meac_pkg::t_status o_status,
    input  logic [7:0]        i_light,
    input  logic [15:0]       i_temp,
    input  logic [15:0]       i_humid,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [7:0]        i_cfg_data,
    output logic [119:0]      o_result
);
    import meac_pkg::*;

    localparam int PW = $clog2(WINDOW);
    localparam int FW = $clog2(WINDOW + 1);
    localparam int DW = $clog2(DEBOUNCE + 1);

    logic [1:0] r_mode;
    logic [7:0] r_alpha;
    logic signed [6:0] r_tw, r_ta;
    logic [4:0] r_tb;
    logic [6:0] r_lw, r_la;
    logic [5:0] r_lb;

    logic signed [15:0] r_lwin [WINDOW];
    logic signed [15:0] r_twin [WINDOW];
    logic signed [15:0] r_hwin [WINDOW];
    logic [PW-1:0] r_pos;
    logic [FW-1:0] r_fill;

    // sort buffers
    logic signed [15:0] r_ls [WINDOW];
    logic signed [15:0] r_ts [WINDOW];
    logic signed [15:0] r_hs [WINDOW];
    logic [FW-1:0] r_cnt;

    logic signed [15:0] n_ls [WINDOW];
    logic signed [15:0] n_ts [WINDOW];
    logic signed [15:0] n_hs [WINDOW];

    logic signed [15:0] r_l, r_t, r_h;
    logic signed [15:0] r_lavg, r_tavg, r_havg;
    logic r_started;

    logic [1:0] r_tnow, r_tpend, r_lnow, r_lpend, r_ovp;
    logic [DW-1:0] r_tagree, r_lagree;
    logic [31:0] r_trise, r_lrise;
    logic [14:0] r_ol, r_ot, r_oh;
    logic [1:0] r_ov;
    logic r_chg;

    logic use_med, use_ema;
    assign use_med = (r_mode == MODE_FULL) || (r_mode == MODE_MEDIAN);
    assign use_ema = (r_mode == MODE_FULL) || (r_mode == MODE_EMA);

    logic signed [15:0] sat_l, sat_t, sat_h;
    always_comb begin
        sat_l = (i_light > 8'd100) ? 16'sd25600 : 16'({i_light, 8'd0});
        sat_t = $signed(i_temp);
        if (sat_t < -16'sd2560) sat_t = -16'sd2560;
        else if (sat_t > 16'sd15360) sat_t = 16'sd15360;
        sat_h = $signed(i_humid);
        if (sat_h < 16'sd0) sat_h = 16'sd0;
        else if (sat_h > 16'sd25600) sat_h = 16'sd25600;
    end

    // one odd-even transposition pass per step over the valid entries
    always_comb begin
        n_ls = r_ls; n_ts = r_ts; n_hs = r_hs;
        for (int i = 0; i + 1 < WINDOW; i++) begin
            if ((i[0] == r_cnt[0]) && (FW'(i + 1) < r_fill)) begin
                if (r_ls[i] > r_ls[i+1]) begin
                    n_ls[i] = r_ls[i+1]; n_ls[i+1] = r_ls[i];
                end
                if (r_ts[i] > r_ts[i+1]) begin
                    n_ts[i] = r_ts[i+1]; n_ts[i+1] = r_ts[i];
                end
                if (r_hs[i] > r_hs[i+1]) begin
                    n_hs[i] = r_hs[i+1]; n_hs[i+1] = r_hs[i];
                end
            end
        end
    end

    function automatic logic signed [15:0] ema(input logic signed [15:0] avg,
                                               input logic signed [15:0] s,
                                               input logic [7:0] al);
        logic signed [26:0] acc;
        acc = $signed({19'd0, al}) * 27'(s)
            + $signed(27'(9'd256 - {1'b0, al})) * 27'(avg) + 27'sd128;
        return acc[23:8];
    endfunction

    function automatic logic [1:0] classify(input logic signed [15:0] v,
                                            input logic [1:0] cur,
                                            input logic signed [8:0] w,
                                            input logic signed [8:0] a,
                                            input logic signed [8:0] b);
        logic signed [17:0] vv;
        logic [1:0] r;
        vv = 18'(v);
        r = cur;
        case (cur)
            LVL_NORMAL: if (vv >= 18'(w) * 18'sd256) r = LVL_WARN;
            LVL_WARN: begin
                if (vv >= 18'(a) * 18'sd256) r = LVL_ALERT;
                else if (vv < (18'(w) - 18'(b)) * 18'sd256) r = LVL_NORMAL;
            end
            default: if (vv < (18'(a) - 18'(b)) * 18'sd256) r = LVL_WARN;
        endcase
        return r;
    endfunction

    logic [1:0] ct, cl, tn, ln, tp, lp;
    logic [DW-1:0] ta, la;
    logic [1:0] ov;
    always_comb begin
        ct = classify(r_t, r_tnow, 9'(r_tw), 9'(r_ta), $signed({4'd0, r_tb}));
        cl = classify(r_l, r_lnow, $signed({2'd0, r_lw}), $signed({2'd0, r_la}),
                      $signed({3'd0, r_lb}));
        tn = r_tnow; tp = r_tpend; ta = r_tagree;
        if (ct == r_tnow) begin
            ta = '0; tp = r_tnow;
        end else begin
            if (ct == r_tpend) ta = r_tagree + DW'(1);
            else begin tp = ct; ta = DW'(1); end
            if (ta >= DW'(DEBOUNCE)) begin ta = '0; tn = ct; end
        end
        ln = r_lnow; lp = r_lpend; la = r_lagree;
        if (cl == r_lnow) begin
            la = '0; lp = r_lnow;
        end else begin
            if (cl == r_lpend) la = r_lagree + DW'(1);
            else begin lp = cl; la = DW'(1); end
            if (la >= DW'(DEBOUNCE)) begin la = '0; ln = cl; end
        end
        ov = (tn > ln) ? tn : ln;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_FULL; r_alpha <= 8'd77;
            r_tw <= 7'sd28; r_ta <= 7'sd32; r_tb <= 5'd2;
            r_lw <= 7'd60; r_la <= 7'd75; r_lb <= 6'd5;
            for (int i = 0; i < WINDOW; i++) begin
                r_lwin[i] <= '0; r_twin[i] <= '0; r_hwin[i] <= '0;
            end
            r_pos <= '0; r_fill <= '0; r_cnt <= '0;
            r_lavg <= '0; r_tavg <= '0; r_havg <= '0; r_started <= 1'b0;
            r_tnow <= LVL_NORMAL; r_tpend <= LVL_NORMAL; r_tagree <= '0;
            r_lnow <= LVL_NORMAL; r_lpend <= LVL_NORMAL; r_lagree <= '0;
            r_ovp <= LVL_NORMAL; r_trise <= '0; r_lrise <= '0;
            r_ov <= LVL_NORMAL; r_chg <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MODE:        r_mode  <= i_cfg_data[1:0];
                    REG_ALPHA:       r_alpha <= i_cfg_data;
                    REG_TEMP_WARN:   r_tw    <= i_cfg_data[6:0];
                    REG_TEMP_ALARM:  r_ta    <= i_cfg_data[6:0];
                    REG_TEMP_BAND:   r_tb    <= i_cfg_data[4:0];
                    REG_LIGHT_WARN:  r_lw    <= i_cfg_data[6:0];
                    REG_LIGHT_ALARM: r_la    <= i_cfg_data[6:0];
                    REG_LIGHT_BAND:  r_lb    <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_l <= sat_l; r_t <= sat_t; r_h <= sat_h;
                r_cnt <= '0;
                if (use_med) begin
                    for (int i = 0; i < WINDOW; i++) begin
                        r_ls[i] <= (PW'(i) == r_pos) ? sat_l : r_lwin[i];
                        r_ts[i] <= (PW'(i) == r_pos) ? sat_t : r_twin[i];
                        r_hs[i] <= (PW'(i) == r_pos) ? sat_h : r_hwin[i];
                    end
                    r_lwin[r_pos] <= sat_l; r_twin[r_pos] <= sat_t;
                    r_hwin[r_pos] <= sat_h;
                    r_pos <= (r_pos == PW'(WINDOW - 1)) ? '0 : r_pos + PW'(1);
                    if (r_fill != FW'(WINDOW)) r_fill <= r_fill + FW'(1);
                end
            end
            if (i_cmd.sort_step) begin
                r_ls <= n_ls;
                r_ts <= n_ts;
                r_hs <= n_hs;
                r_cnt <= r_cnt + FW'(1);
                if (o_status.sort_done) begin
                    r_l <= r_ls[r_fill >> 1]; r_t <= r_ts[r_fill >> 1];
                    r_h <= r_hs[r_fill >> 1];
                end
            end
            if (i_cmd.ema && use_ema) begin
                if (!r_started) begin
                    r_lavg <= r_l; r_tavg <= r_t; r_havg <= r_h;
                    r_started <= 1'b1;
                end else begin
                    r_lavg <= ema(r_lavg, r_l, r_alpha); r_l <= ema(r_lavg, r_l, r_alpha);
                    r_tavg <= ema(r_tavg, r_t, r_alpha); r_t <= ema(r_tavg, r_t, r_alpha);
                    r_havg <= ema(r_havg, r_h, r_alpha); r_h <= ema(r_havg, r_h, r_alpha);
                end
            end
            if (i_cmd.classify) begin
                r_tnow <= tn; r_tpend <= tp; r_tagree <= ta;
                r_lnow <= ln; r_lpend <= lp; r_lagree <= la;
                if (tn > r_tnow) r_trise <= r_trise + 32'd1;
                if (ln > r_lnow) r_lrise <= r_lrise + 32'd1;
                r_ov <= ov; r_chg <= (ov != r_ovp); r_ovp <= ov;
                r_ol <= r_l[14:0]; r_ot <= r_t[14:0]; r_oh <= r_h[14:0];
            end
        end
    end

    assign o_status.use_median = use_med;
    assign o_status.sort_done  = (r_cnt == FW'(WINDOW));
    assign o_result = {4'd0, r_lrise, r_trise, r_chg, r_ov, r_lnow, r_tnow,
                       r_oh, r_ot, r_ol};

`ifndef SYNTH
    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(WINDOW)) else $error("window fill overflow");
    a_agree_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tagree < DW'(DEBOUNCE) && r_lagree < DW'(DEBOUNCE))
        else $error("debounce count overflow");
    a_ov_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.classify |=> r_ov == ((r_tnow > r_lnow) ? r_tnow : r_lnow))
        else $error("overall level mismatch");
`endif
endmodule

### design/meac_ctrl.sv
// controller state machine sequencing load, sort passes, ema and classify
// depends on meac_pkg
module meac_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  meac_pkg::t_status i_status,
    output meac_pkg::t_cmd    o_cmd
);
    import meac_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = i_status.use_median ? ST_SORT : ST_EMA;
                end
            end
            ST_SORT: begin
                o_cmd.sort_step = 1'b1;
                if (i_status.sort_done) n_state = ST_EMA;
            end
            ST_EMA: begin
                o_cmd.ema = 1'b1;
                n_state = ST_CLASS;
            end
            ST_CLASS: begin
                o_cmd.classify = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef SYNTH
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd)) else $error("overlapping commands");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == ST_SORT || r_state == ST_EMA)
        else $error("load without progress");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid) else $error("result dropped");
`endif
endmodule

### design/median_ema_alert_conditioner.sv
// sequence from input accept to result accept: sort passes when the median is in use,
// then ema, classify and out; ema-only and bypass modes skip the sort passes; the
// result then waits in out until m_axis_tready accepts it
// one word at a time: a new word is accepted only after the previous result is accepted
// reset: i_rst_n synchronous active low restores config registers to defaults, clears state
// top level; depends on meac_pkg, meac_ctrl, meac_datapath
module median_ema_alert_conditioner #(
    parameter int WINDOW   = meac_pkg::WINDOW_DEF,
    parameter int DEBOUNCE = meac_pkg::DEBOUNCE_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,  // light_sample, temp_sample, humid_sample
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // light_filtered, temp_filtered, humid_filtered, temp_grade, light_grade,
    // overall_grade, grade_changed, temp_rises, light_rises
    output logic [119:0] m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [7:0]   i_cfg_data
);
    import meac_pkg::*;

    t_cmd    cmd;
    t_status status;

    meac_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_status(status), .o_cmd(cmd)
    );

    meac_datapath #(.WINDOW(WINDOW), .DEBOUNCE(DEBOUNCE)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_light(s_axis_tdata[7:0]), .i_temp(s_axis_tdata[23:8]),
        .i_humid(s_axis_tdata[39:24]),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_result(m_axis_tdata)
    );
endmodule

### test/median_ema_alert_conditioner_test.sv
// testbench for median_ema_alert_conditioner: random and directed sensor words,
// results checked against a behavioral predictor; depends on meac_pkg and the rtl
module median_ema_alert_conditioner_test;
    import meac_pkg::*;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata = '0;   // light_sample, temp_sample, humid_sample
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // light_filtered, temp_filtered, humid_filtered, temp_grade, light_grade,
    // overall_grade, grade_changed, temp_rises, light_rises
    logic [119:0] m_axis_tdata;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_idx = '0;
    logic [7:0]   i_cfg_data = '0;

    median_ema_alert_conditioner dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic [1:0] p_mode;
    int p_alpha, p_twarn, p_talarm, p_tband, p_lwarn, p_lalarm, p_lband;
    int win_l[5], win_t[5], win_h[5];
    int wpos, wfill;
    int avg_l, avg_t, avg_h;
    bit avg_on;
    logic [1:0] t_now, t_pend, l_now, l_pend, ov_prev;
    int t_agree, l_agree;
    logic [31:0] t_rises, l_rises;

    logic [119:0] expected_words[$];
    int  errors = 0;
    bit  quiet = 1'b0;
    int  stall_hold = 0;
    int  long_stalls = 0;
    int  long_seen = 0;

    function automatic int median5(int w[5], int n);
        int b[5];
        int k, j, tmp;
        for (k = 0; k < n; k++) b[k] = w[k];
        for (k = 1; k < n; k++)
            for (j = k; j > 0 && b[j-1] > b[j]; j--) begin
                tmp = b[j]; b[j] = b[j-1]; b[j-1] = tmp;
            end
        return b[n/2];
    endfunction

    function automatic int ema_step(int avg, int s);
        int t;
        t = p_alpha * s + (256 - p_alpha) * avg + 128;
        return t >= 0 ? t / 256 : -((-t + 255) / 256);
    endfunction

    function automatic logic [1:0] grade_of(int v, logic [1:0] cur, int w, int a, int b);
        if (cur == LVL_NORMAL) begin
            if (v >= w * 256) return LVL_WARN;
        end else if (cur == LVL_WARN) begin
            if (v >= a * 256) return LVL_ALERT;
            if (v < (w - b) * 256) return LVL_NORMAL;
        end else begin
            if (v < (a - b) * 256) return LVL_WARN;
        end
        return cur;
    endfunction

    task automatic debounce_step(inout logic [1:0] cur, inout logic [1:0] pend,
                                 inout int agree, input logic [1:0] cand);
        if (cand == cur) begin
            agree = 0;
            pend = cur;
        end else begin
            if (cand == pend) agree = (agree + 1) & 15;
            else begin
                pend = cand;
                agree = 1;
            end
            if (agree >= DEBOUNCE_DEF) begin
                agree = 0;
                cur = cand;
            end
        end
    endtask

    task automatic predict_word(logic [39:0] w);
        int l, t, h;
        logic [1:0] ct, cl, pt, pl, ov;
        logic [14:0] fl, ft, fh;
        l = (w[7:0] > 100 ? 100 : w[7:0]) * 256;
        t = $signed(w[23:8]);
        t = t < -2560 ? -2560 : (t > 15360 ? 15360 : t);
        h = $signed(w[39:24]);
        h = h < 0 ? 0 : (h > 25600 ? 25600 : h);
        if (p_mode == MODE_FULL || p_mode == MODE_MEDIAN) begin
            win_l[wpos] = l; win_t[wpos] = t; win_h[wpos] = h;
            wpos = (wpos + 1) % 5;
            if (wfill < 5) wfill++;
            l = median5(win_l, wfill);
            t = median5(win_t, wfill);
            h = median5(win_h, wfill);
        end
        if (p_mode == MODE_FULL || p_mode == MODE_EMA) begin
            if (!avg_on) begin
                avg_l = l; avg_t = t; avg_h = h;
                avg_on = 1'b1;
            end else begin
                avg_l = ema_step(avg_l, l);
                avg_t = ema_step(avg_t, t);
                avg_h = ema_step(avg_h, h);
            end
            l = avg_l; t = avg_t; h = avg_h;
        end
        ct = grade_of(t, t_now, p_twarn, p_talarm, p_tband);
        cl = grade_of(l, l_now, p_lwarn, p_lalarm, p_lband);
        pt = t_now;
        pl = l_now;
        debounce_step(t_now, t_pend, t_agree, ct);
        debounce_step(l_now, l_pend, l_agree, cl);
        if (t_now > pt) t_rises++;
        if (l_now > pl) l_rises++;
        ov = t_now > l_now ? t_now : l_now;
        fl = l[14:0]; ft = t[14:0]; fh = h[14:0];
        expected_words.push_back({4'b0000, l_rises, t_rises, (ov != ov_prev), ov, l_now,
                                  t_now, fh, ft, fl});
        ov_prev = ov;
    endtask

    task automatic reset_predictor();
        p_mode = MODE_FULL; p_alpha = 77;
        p_twarn = 28; p_talarm = 32; p_tband = 2;
        p_lwarn = 60; p_lalarm = 75; p_lband = 5;
        win_l = '{default: 0}; win_t = '{default: 0}; win_h = '{default: 0};
        wpos = 0; wfill = 0;
        avg_l = 0; avg_t = 0; avg_h = 0; avg_on = 1'b0;
        t_now = LVL_NORMAL; t_pend = LVL_NORMAL; l_now = LVL_NORMAL;
        l_pend = LVL_NORMAL; ov_prev = LVL_NORMAL;
        t_agree = 0; l_agree = 0; t_rises = 0; l_rises = 0;
    endtask

    task automatic send_word(logic [39:0] w);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        s_axis_tdata <= w;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_word(w);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        case (idx)
            REG_MODE:        p_mode = val[1:0];
            REG_ALPHA:       p_alpha = val;
            REG_TEMP_WARN:   p_twarn = $signed(val[6:0]);
            REG_TEMP_ALARM:  p_talarm = $signed(val[6:0]);
            REG_TEMP_BAND:   p_tband = val[4:0];
            REG_LIGHT_WARN:  p_lwarn = val[6:0];
            REG_LIGHT_ALARM: p_lalarm = val[6:0];
            REG_LIGHT_BAND:  p_lband = val[5:0];
        endcase
    endtask

    function automatic logic [39:0] rand_word();
        logic [15:0] t, h;
        logic [7:0] l;
        case ($urandom_range(0, 5))
            0: begin l = 8'($urandom); t = 16'($urandom); h = 16'($urandom); end
            default: begin
                l = 8'($urandom_range(0, 110));
                t = 16'($urandom_range(0, 18000)) - 16'd2800;
                h = 16'($urandom_range(0, 26000)) - 16'd200;
            end
        endcase
        return {h, t, l};
    endfunction

    // noisy ramps that drive the classifiers through all levels
    task automatic send_ramp(int n);
        int k, tv, lv;
        for (k = 0; k < n; k++) begin
            tv = 20 * 256 + $signed(16'($urandom_range(0, 4000))) * ((k % 40) < 20 ? 1 : -1);
            lv = 50 + (k % 40) + $urandom_range(0, 4);
            send_word({16'($urandom_range(0, 25600)), 16'(tv), 8'(lv)});
        end
    endtask

    task automatic test_directed();
        send_word({16'h0000, 16'h0000, 8'd0});
        send_word({16'hFFFF, 16'hFFFF, 8'hFF});
        send_word({16'h8000, 16'h8000, 8'd100});
        send_word({16'h7FFF, 16'h7FFF, 8'd101});
        send_word({16'd25600, 16'd15360, 8'd100});
        send_word({16'd25601, 16'd15361, 8'd99});
        send_word({16'h0000, 16'hF600, 8'd0});
        send_word({16'h5555, 16'hAAAA, 8'h55});
        send_word({16'hAAAA, 16'h5555, 8'hAA});
        repeat (6) send_word({16'd12800, 16'd15360, 8'd100});
        repeat (6) send_word({16'd0, 16'hF600, 8'd0});
        wait_idle();
    endtask

    task automatic test_modes();
        int m;
        logic [7:0] alphas[4] = '{8'd0, 8'd255, 8'd1, 8'd128};
        for (m = 0; m < 4; m++) begin
            write_reg(REG_MODE, 8'(m) | 8'hFC);
            write_reg(REG_ALPHA, alphas[m]);
            send_ramp(60);
            repeat (40) send_word(rand_word());
            wait_idle();
        end
    endtask

    task automatic test_thresholds();
        write_reg(REG_MODE, {6'd0, MODE_MEDIAN});
        write_reg(REG_TEMP_WARN, 8'h76);     // -10
        write_reg(REG_TEMP_ALARM, 8'd60);
        write_reg(REG_TEMP_BAND, 8'd20);
        write_reg(REG_LIGHT_WARN, 8'd0);
        write_reg(REG_LIGHT_ALARM, 8'd100);
        write_reg(REG_LIGHT_BAND, 8'd50);
        send_ramp(80);
        wait_idle();
        write_reg(REG_MODE, {6'd0, MODE_BYPASS});
        write_reg(REG_TEMP_WARN, 8'd40);     // warn above alarm
        write_reg(REG_TEMP_ALARM, 8'd25);
        write_reg(REG_TEMP_BAND, 8'd0);
        write_reg(REG_LIGHT_WARN, 8'd90);
        write_reg(REG_LIGHT_ALARM, 8'd55);
        write_reg(REG_LIGHT_BAND, 8'd0);
        send_ramp(80);
        repeat (40) send_word(rand_word());
        wait_idle();
        write_reg(REG_TEMP_WARN, 8'd24);
        write_reg(REG_TEMP_ALARM, 8'd30);
        write_reg(REG_TEMP_BAND, 8'd3);
        write_reg(REG_LIGHT_WARN, 8'd65);
        write_reg(REG_LIGHT_ALARM, 8'd80);
        write_reg(REG_LIGHT_BAND, 8'd6);
    endtask

    task automatic test_backpressure();
        write_reg(REG_MODE, {6'd0, MODE_FULL});
        write_reg(REG_ALPHA, 8'd90);
        long_stalls++;
        repeat (20) send_word(rand_word());
        wait_idle();
    endtask

    task automatic test_random();
        int k, m;
        for (k = 0; k < 4; k++) begin
            m = $urandom_range(0, 3);
            write_reg(REG_MODE, 8'(m));
            write_reg(REG_ALPHA, 8'($urandom));
            send_ramp(60);
            repeat (60) send_word(rand_word());
            wait_idle();
        end
        quiet = 1'b1;
        write_reg(REG_MODE, {6'd0, MODE_FULL});
        send_ramp(60);
        repeat (40) send_word(rand_word());
    endtask

    // receiver: random stalls, plus one long hold requested by the test
    always @(negedge i_clk) begin
        if (long_seen != long_stalls) begin
            long_seen <= long_stalls;
            m_axis_tready <= 1'b0;
            stall_hold <= 300;
        end else if (stall_hold > 0) begin
            m_axis_tready <= 1'b0;
            stall_hold <= stall_hold - 1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            stall_hold <= $urandom_range(0, 5);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h", $time, m_axis_tdata);
                errors++;
            end else if (m_axis_tdata !== expected_words[0]) begin
                $display("%0t: mismatch, expected %h, actual %h", $time, expected_words[0],
                         m_axis_tdata);
                errors++;
                void'(expected_words.pop_front());
            end else begin
                void'(expected_words.pop_front());
            end
        end
    end

    initial begin
        reset_predictor();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_modes();
        test_thresholds();
        test_backpressure();
        test_random();
        wait_idle();
        if (errors == 0 && expected_words.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #400000;
        $display("tb: failure");
        $finish;
    end
endmodule
